// ===== design/msbr_pkg.sv =====
package msbr_pkg;

    localparam int QUEUE_BYTES   = 16;
    localparam int MAX_READ_BITS = 64;

    localparam int COUNT_W = 24;
    localparam int VALUE_W = 64;
    localparam int SHIFT_W = 4;

    localparam logic [COUNT_W-1:0] PEND_MAX = 24'hFFFFFF;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_SKIP   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_BADCOUNT = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data_byte;
        logic [COUNT_W-1:0] bit_count;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic               load;
    } t_cell_ctl;

endpackage

// ===== design/msbr_cell.sv =====
module msbr_cell #(
    parameter int SHIFT_MAX = 8
) (
    input  logic                        i_clk,
    input  msbr_pkg::t_cell_ctl         i_ctl,
    input  logic [SHIFT_MAX-1:0][7:0]   i_nbr,
    input  logic [7:0]                  i_data,
    output logic [7:0]                  o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Take the byte from the neighbor that lies shift cells downstream; with no shift, load i_data or hold.
    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift == '0) begin
            if (i_ctl.load) begin
                n_byte = i_data;
            end
        end else begin
            for (int k = 0; k < SHIFT_MAX; k++) begin
                if (i_ctl.shift == msbr_pkg::SHIFT_W'(k + 1)) begin
                    n_byte = i_nbr[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

// ===== design/msbr_extract.sv =====
module msbr_extract #(
    parameter int MAX_READ_BITS = 64
) (
    input  logic [((MAX_READ_BITS + 14) / 8) * 8 - 1:0] i_win,
    input  logic [2:0]                                  i_bit_off,
    input  logic [$clog2(MAX_READ_BITS + 1) - 1:0]      i_bits,
    output logic [msbr_pkg::VALUE_W-1:0]                o_value
);

    localparam int WW  = ((MAX_READ_BITS + 14) / 8) * 8;
    localparam int XW  = (WW > msbr_pkg::VALUE_W) ? WW : msbr_pkg::VALUE_W;
    localparam int SW  = $clog2(WW + 1);

    logic [WW-1:0] w_aligned;
    logic [SW-1:0] w_rsh;
    logic [XW-1:0] w_ext;

    // Drop the consumed head bits, then right-align the requested field.
    assign w_aligned = i_win << i_bit_off;
    assign w_rsh     = SW'(WW) - SW'(i_bits);
    assign w_ext     = XW'(w_aligned) >> w_rsh;
    assign o_value   = w_ext[msbr_pkg::VALUE_W-1:0];

endmodule

// ===== design/msb_first_bit_reader_core.sv =====
// MSB-first bitstream reader with a byte queue.
//
// Input channel (i_valid / o_stall, payload i_item): each transaction appends
// a byte, reads 1 to MAX_READ_BITS bits most significant first, or skips any
// number of bits. Output channel (o_valid / i_stall, payload o_result): one
// transaction per input transaction, in order, with the right-aligned value
// and a status (ok, short, bad count, queue full).
// The result sits in the output register the cycle after acceptance.
// Throughput is one transaction per cycle while no skip is draining and the
// receiver does not stall. A skip that drops more than (MAX_READ_BITS+7)/8
// buffered bytes holds o_stall until the byte chain, shifting at most that
// many cells per cycle, has dropped them all.
// While the receiver stalls, the result holds in the output register and
// o_stall rises once a further result would overwrite it.
// Reset clears the fill count, bit offset, pending discard count and the
// output valid; the queue bytes are not cleared and are only read once
// written.
module msb_first_bit_reader_core #(
    parameter int QUEUE_BYTES   = msbr_pkg::QUEUE_BYTES,
    parameter int MAX_READ_BITS = msbr_pkg::MAX_READ_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  msbr_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output msbr_pkg::t_out_item o_result
);

    localparam int FW  = $clog2(QUEUE_BYTES + 1);
    localparam int SM  = (MAX_READ_BITS + 7) / 8;
    localparam int WIN = (MAX_READ_BITS + 14) / 8;
    localparam int WW  = WIN * 8;
    localparam int AW  = FW + 3;
    localparam int RBW = $clog2(MAX_READ_BITS + 1);
    localparam int CW  = msbr_pkg::COUNT_W;

    // Queue state: head byte always in cell 0.
    logic [FW-1:0]  r_fill;
    logic [FW-1:0]  n_fill;
    logic [2:0]     r_bit_off;
    logic [2:0]     n_bit_off;
    logic [CW-1:0]  r_pending;
    logic [CW-1:0]  n_pending;
    logic [FW-1:0]  r_drain;
    logic [FW-1:0]  n_drain;

    logic                r_out_valid;
    logic                n_out_valid;
    msbr_pkg::t_out_item r_out;
    msbr_pkg::t_out_item n_out;

    logic                  w_in_accept;
    logic [AW-1:0]         w_avail;
    logic                  w_short;
    logic                  w_bad;
    logic [CW:0]           w_total;
    logic [FW-1:0]         w_total_bytes;
    logic [FW-1:0]         w_step_src;
    logic [FW-1:0]         w_step_min;
    logic [msbr_pkg::SHIFT_W-1:0] w_step;
    logic                  w_store;
    logic                  w_flush;
    logic                  w_rd_ok;
    logic [1:0]            w_status;
    logic [CW:0]           w_excess;
    logic [7:0]            w_cell [QUEUE_BYTES];
    logic [WW-1:0]         w_win;
    logic [msbr_pkg::VALUE_W-1:0] w_value;

    // Accept unless a large skip is still draining or the result would be lost.
    assign o_stall     = (r_drain != '0) || (r_out_valid && i_stall);
    assign w_in_accept = i_valid && !o_stall;

    assign w_avail = {r_fill, 3'b000} - AW'(r_bit_off);
    assign w_short = i_item.bit_count > CW'(w_avail);
    assign w_bad   = (i_item.bit_count == '0) ||
                     (i_item.bit_count > CW'(MAX_READ_BITS));

    // Shared by read and skip: bit position after consuming bit_count bits.
    assign w_total       = {1'b0, i_item.bit_count} + (CW + 1)'(r_bit_off);
    assign w_total_bytes = w_total[FW+2:3];

    // Limit every chain shift to what the neighbor window reaches.
    assign w_step_src = (r_drain != '0) ? r_drain : w_total_bytes;
    assign w_step_min = (w_step_src > FW'(SM)) ? FW'(SM) : w_step_src;

    assign w_excess = {1'b0, i_item.bit_count} - (CW + 1)'(w_avail)
                    + {1'b0, r_pending};

    always_comb begin
        n_bit_off = r_bit_off;
        n_pending = r_pending;
        n_drain   = r_drain;
        w_step    = '0;
        w_store   = 1'b0;
        w_flush   = 1'b0;
        w_rd_ok   = 1'b0;
        w_status  = msbr_pkg::ST_OK;
        if (r_drain != '0) begin
            // Pay off the remaining bytes of a skip.
            w_step  = msbr_pkg::SHIFT_W'(w_step_min);
            n_drain = r_drain - w_step_min;
        end else if (w_in_accept) begin
            unique case (i_item.kind)
                msbr_pkg::KIND_APPEND: begin
                    if (r_pending >= CW'(8)) begin
                        n_pending = r_pending - CW'(8);
                    end else if (r_fill == FW'(QUEUE_BYTES)) begin
                        w_status = msbr_pkg::ST_FULL;
                    end else begin
                        w_store = 1'b1;
                        if (r_pending != '0) begin
                            n_bit_off = r_pending[2:0];
                            n_pending = '0;
                        end
                    end
                end
                msbr_pkg::KIND_READ: begin
                    if (w_bad) begin
                        w_status = msbr_pkg::ST_BADCOUNT;
                    end else if (w_short) begin
                        w_status = msbr_pkg::ST_SHORT;
                    end else begin
                        w_rd_ok   = 1'b1;
                        w_step    = msbr_pkg::SHIFT_W'(w_step_min);
                        n_bit_off = w_total[2:0];
                    end
                end
                msbr_pkg::KIND_SKIP: begin
                    if (!w_short) begin
                        w_step    = msbr_pkg::SHIFT_W'(w_step_min);
                        n_drain   = w_total_bytes - w_step_min;
                        n_bit_off = w_total[2:0];
                    end else begin
                        // Empty the queue and carry the missing bits forward.
                        w_flush   = 1'b1;
                        n_bit_off = '0;
                        n_pending = (w_excess > (CW + 1)'(msbr_pkg::PEND_MAX)) ?
                                    msbr_pkg::PEND_MAX : w_excess[CW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
        if (w_flush) begin
            n_fill = '0;
        end else begin
            n_fill = r_fill - FW'(w_step) + FW'(w_store);
        end
    end

    // Byte chain: cell i shifts in from cells i+1 .. i+SM.
    for (genvar i = 0; i < QUEUE_BYTES; i++) begin : g_cell
        logic [SM-1:0][7:0]  w_nbr;
        msbr_pkg::t_cell_ctl w_ctl;

        for (genvar k = 0; k < SM; k++) begin : g_nbr
            if (i + k + 1 < QUEUE_BYTES) begin : g_in
                assign w_nbr[k] = w_cell[i + k + 1];
            end else begin : g_end
                assign w_nbr[k] = '0;
            end
        end

        assign w_ctl.shift = w_step;
        assign w_ctl.load  = w_store && (r_fill == FW'(i));

        msbr_cell #(
            .SHIFT_MAX (SM)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_nbr  (w_nbr),
            .i_data (i_item.data_byte),
            .o_byte (w_cell[i])
        );
    end

    // Head window, cell 0 in the top byte.
    for (genvar j = 0; j < WIN; j++) begin : g_win
        assign w_win[WW - 1 - 8 * j -: 8] = w_cell[j];
    end

    msbr_extract #(
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_extract (
        .i_win     (w_win),
        .i_bit_off (r_bit_off),
        .i_bits    (i_item.bit_count[RBW-1:0]),
        .o_value   (w_value)
    );

    // Output register: load on accept, drop once the receiver takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_in_accept) begin
            n_out_valid  = 1'b1;
            n_out.value  = w_rd_ok ? w_value : '0;
            n_out.status = w_status;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_bit_off   <= '0;
            r_pending   <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_bit_off   <= n_bit_off;
            r_pending   <= n_pending;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(QUEUE_BYTES))
        else $error("fill count beyond queue depth");

    a_offset_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_off != '0 |-> r_fill != '0)
        else $error("bit offset set on an empty queue");

    a_pending_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != '0 |-> (r_fill == '0 && r_drain == '0))
        else $error("pending discard with buffered bytes");

    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain != '0 |=> $past(r_out_valid && i_stall) || !r_out_valid ||
                          $past(r_out_valid) == r_out_valid)
        else $error("result produced while draining");
`endif

endmodule

// ===== test/tb_msb_first_bit_reader_core.sv =====
module tb_msb_first_bit_reader_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind 3 has no package name; the block must treat it as a no-op.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Scoreboard: tracks the bit reader state on the side and holds one
    // expected answer per accepted transaction, oldest first.
    class bitreader_scoreboard;
        typedef struct {
            msbr_pkg::t_in_item  req;
            msbr_pkg::t_out_item res;
        } t_due;

        logic [7:0]  store [msbr_pkg::QUEUE_BYTES];
        int unsigned head;
        int unsigned fill;
        int unsigned ofs;
        int unsigned pend;
        t_due        results_due [$];
        int          faults;
        int          kinds [4];
        int          statuses [4];

        function new();
            head = 0;
            fill = 0;
            ofs  = 0;
            pend = 0;
            faults = 0;
            foreach (kinds[k]) kinds[k] = 0;
            foreach (statuses[k]) statuses[k] = 0;
        endfunction

        function void consume_bits(int unsigned nbits);
            int unsigned total;
            total = ofs + nbits;
            head  = (head + total / 8) % msbr_pkg::QUEUE_BYTES;
            fill  = fill - total / 8;
            ofs   = total % 8;
        endfunction

        // Work out the answer to one transaction and advance the state.
        function msbr_pkg::t_out_item unpack_bits(msbr_pkg::t_in_item it);
            msbr_pkg::t_out_item r;
            int unsigned         cnt;
            int unsigned         avail;
            int unsigned         pos;
            logic [7:0]          src;
            longint unsigned     extra;
            r     = '0;
            cnt   = 32'(it.bit_count);
            avail = fill * 8 - ofs;
            case (it.kind)
                msbr_pkg::KIND_APPEND: begin
                    if (pend >= 8) begin
                        pend = pend - 8;
                    end else if (fill >= msbr_pkg::QUEUE_BYTES) begin
                        r.status = msbr_pkg::ST_FULL;
                    end else begin
                        store[(head + fill) % msbr_pkg::QUEUE_BYTES] = it.data_byte;
                        fill = fill + 1;
                        if (pend != 0) begin
                            ofs  = pend % 8;
                            pend = 0;
                        end
                    end
                end
                msbr_pkg::KIND_READ: begin
                    if (cnt == 0 || cnt > msbr_pkg::MAX_READ_BITS) begin
                        r.status = msbr_pkg::ST_BADCOUNT;
                    end else if (cnt > avail) begin
                        r.status = msbr_pkg::ST_SHORT;
                    end else begin
                        for (int unsigned i = 0; i < cnt; i++) begin
                            pos = ofs + i;
                            src = store[(head + pos / 8) % msbr_pkg::QUEUE_BYTES];
                            r.value = {r.value[msbr_pkg::VALUE_W-2:0], src[7 - pos % 8]};
                        end
                        consume_bits(cnt);
                    end
                end
                msbr_pkg::KIND_SKIP: begin
                    if (cnt <= avail) begin
                        consume_bits(cnt);
                    end else begin
                        extra = longint'(cnt) - avail + pend;
                        pend  = (extra > 64'(msbr_pkg::PEND_MAX)) ?
                                32'(msbr_pkg::PEND_MAX) : 32'(extra);
                        head  = (head + fill) % msbr_pkg::QUEUE_BYTES;
                        fill  = 0;
                        ofs   = 0;
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_item(msbr_pkg::t_in_item it);
            t_due d;
            d.req = it;
            d.res = unpack_bits(it);
            kinds[it.kind]++;
            statuses[d.res.status]++;
            results_due.push_back(d);
        endfunction

        function void flag(string msg);
            faults++;
            if (faults <= 10) $display("%s", msg);
        endfunction

        function void check_result(msbr_pkg::t_out_item got);
            t_due d;
            if (results_due.size() == 0) begin
                flag($sformatf("unexpected result: value %h status %0d",
                               got.value, got.status));
                return;
            end
            d = results_due.pop_front();
            if (got.value !== d.res.value || got.status !== d.res.status) begin
                flag($sformatf({"mismatch (kind %0d count %0d byte %h): ",
                                "expected value %h status %0d, got value %h status %0d"},
                               d.req.kind, d.req.bit_count, d.req.data_byte,
                               d.res.value, d.res.status, got.value, got.status));
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    msbr_pkg::t_in_item  i_item  = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    msbr_pkg::t_out_item o_result;

    bitreader_scoreboard sb;

    // Sender idles in stretches: busy stretches draw a gap per transaction,
    // quiet stretches push back to back.
    bit tx_quiet = 1'b0;
    int tx_left  = 40;

    msb_first_bit_reader_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Sample both channels at the edge; inputs are driven by NBA so the
    // values seen here are the ones the block sampled too.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_item(i_item);
            if (o_valid && !i_stall) sb.check_result(o_result);
        end
    end

    function automatic msbr_pkg::t_in_item mk(logic [1:0] k, logic [7:0] d,
                                              logic [msbr_pkg::COUNT_W-1:0] c);
        msbr_pkg::t_in_item it;
        it.kind      = k;
        it.data_byte = d;
        it.bit_count = c;
        return it;
    endfunction

    // Offer one transaction, hold it until accepted.
    task automatic push_item(msbr_pkg::t_in_item it);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        tx_left--;
        if (tx_left == 0) begin
            tx_quiet = !tx_quiet;
            tx_left  = $urandom_range(20, 90);
        end
    endtask

    // Drop valid and hold off until every outstanding answer has arrived.
    task automatic settle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.results_due.size() != 0);
        @(posedge i_clk);
    endtask

    // Receiver: per result, stall for a random number of cycles, then take it.
    initial begin : rx_side
        int  hold;
        int  left;
        bit  quiet;
        quiet = 1'b0;
        left  = $urandom_range(20, 80);
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 17);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            left--;
            if (left == 0) begin
                quiet = !quiet;
                left  = $urandom_range(20, 80);
            end
        end
    end

    initial begin : stimulus
        msbr_pkg::t_in_item it;
        int                 pick;
        int                 sel;
        int                 phase_left;
        bit                 filling;

        sb = new();
        filling    = 1'b1;
        phase_left = $urandom_range(10, 50);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads against an empty queue and bad counts, an unused kind and a zero skip.
        push_item(mk(msbr_pkg::KIND_READ, 8'($urandom), 24'd1));
        push_item(mk(msbr_pkg::KIND_READ, 8'($urandom), 24'd0));
        push_item(mk(msbr_pkg::KIND_READ, 8'($urandom), 24'd65));
        push_item(mk(msbr_pkg::KIND_READ, 8'($urandom), 24'h800000));
        push_item(mk(KIND_UNUSED, 8'hFF, 24'h7FFFFF));
        push_item(mk(msbr_pkg::KIND_SKIP, 8'($urandom), 24'd0));
        // Skip past an empty queue: the first byte pays off 8 pending bits,
        // the second lands with a bit offset of 5.
        push_item(mk(msbr_pkg::KIND_SKIP, 8'($urandom), 24'd13));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'h11, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'hB7, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_READ, 8'($urandom), 24'd3));
        // Fill nine bytes, then read the widest field across the first eight of them.
        push_item(mk(msbr_pkg::KIND_APPEND, 8'hFF, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'h00, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'h5A, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'hA5, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'h80, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'h01, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'hC3, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'h3C, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'h7E, 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_READ, 8'($urandom), 24'd64));
        push_item(mk(msbr_pkg::KIND_READ, 8'($urandom), 24'd8));
        push_item(mk(msbr_pkg::KIND_READ, 8'($urandom), 24'd1));

        // Hold the sender until the block has answered everything.
        settle();

        // Random: alternate fill phases (mostly appends, reaches a full queue)
        // with drain phases (mostly reads and skips, reaches shortages).
        for (int n = 0; n < 1700; n++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(10, 50);
            end
            phase_left--;
            pick         = $urandom_range(0, 99);
            it.data_byte = 8'($urandom_range(0, 255));
            it.bit_count = 24'($urandom_range(1, 64));
            if (pick < (filling ? 80 : 25)) begin
                it.kind = msbr_pkg::KIND_APPEND;
            end else if (pick < (filling ? 90 : 70)) begin
                it.kind = msbr_pkg::KIND_READ;
                sel = $urandom_range(0, 19);
                if (sel == 0) begin
                    it.bit_count = $urandom_range(0, 1) ? 24'd0 :
                                   24'($urandom_range(65, msbr_pkg::PEND_MAX));
                end else if (sel < 8) begin
                    it.bit_count = 24'($urandom_range(1, 12));
                end
            end else if (pick < (filling ? 97 : 92)) begin
                it.kind = msbr_pkg::KIND_SKIP;
                it.bit_count = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(41, 300))
                                                          : 24'($urandom_range(0, 40));
            end else begin
                it.kind      = KIND_UNUSED;
                it.bit_count = 24'($urandom_range(0, msbr_pkg::PEND_MAX));
            end
            push_item(it);
            if (n == 850) settle();
        end

        // Saturate the pending discard count last: after this each append is swallowed
        // until the count runs down, so nothing else could be checked.
        push_item(mk(msbr_pkg::KIND_SKIP, 8'($urandom), msbr_pkg::PEND_MAX));
        push_item(mk(msbr_pkg::KIND_SKIP, 8'($urandom), msbr_pkg::PEND_MAX));
        push_item(mk(msbr_pkg::KIND_APPEND, 8'($urandom), 24'($urandom)));
        push_item(mk(msbr_pkg::KIND_READ, 8'($urandom), 24'd1));

        settle();
        repeat (10) @(posedge i_clk);
        if (sb.results_due.size() != 0) sb.flag("answers still outstanding at end of run");

        $display("covered %0d transactions: %0d appends, %0d reads, %0d skips, %0d unused",
                 sb.kinds[0] + sb.kinds[1] + sb.kinds[2] + sb.kinds[3],
                 sb.kinds[msbr_pkg::KIND_APPEND], sb.kinds[msbr_pkg::KIND_READ],
                 sb.kinds[msbr_pkg::KIND_SKIP], sb.kinds[KIND_UNUSED]);
        $display("statuses: %0d ok, %0d short, %0d bad count, %0d full; %0d mismatches",
                 sb.statuses[msbr_pkg::ST_OK], sb.statuses[msbr_pkg::ST_SHORT],
                 sb.statuses[msbr_pkg::ST_BADCOUNT], sb.statuses[msbr_pkg::ST_FULL],
                 sb.faults);
        if (sb.faults == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
design/msbr_pkg.sv
design/msbr_cell.sv
design/msbr_extract.sv
design/msb_first_bit_reader_core.sv
test/tb_msb_first_bit_reader_core.sv
